// ===== hw/rtl/sas_pkg.sv =====
// package with shared types, codes and defaults of the segmented arena allocator
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

    localparam int NUM_SEGMENTS_DEF  = 256;
    localparam int SEGMENT_BYTES_DEF = 8192;

    localparam int CMD_W    = 2;
    localparam int REQ_W    = 14;
    localparam int SEG_ID_W = 8;
    localparam int OFF_W    = 14;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREEZE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_LDS,
        S_A_RD,
        S_A_CHK,
        S_A_WRK,
        S_A_WRS,
        S_CLR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init_step;
        logic accept;
        logic rd_ss;
        logic ld_ss;
        logic rd_k;
        logic set_err;
        logic chk;
        logic wr_k;
        logic wr_ss;
        logic clr_step;
        logic clr_end;
        logic freeze;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic k_at_end;
        logic k_at_ut;
        logic fits;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/segmented_arena_allocator.sv =====
// top level of the segmented arena allocator: controller, datapath and checks
//
// input words carry a command in tuser (allocate, freeze, reset unfrozen
// segments; the fourth code does nothing) and a byte count in tdata.
// every input word gives exactly one output word: segment id and offset in
// tdata, and in tuser a flag that is set when no slot had room
// work per word, from accept to the result register:
//   allocate: scans slots from the search start, one slot at a time, as
//             the scan reads the fill table through its one registered read port
//   no room:  the scan runs from the search start to the last slot
//   freeze:   no table access, and the same for the unused code
//   reset:    clears fills from the search start up to the used top, one fill per cycle
// after reset a clearing pass over all NUM_SEGMENTS slots loads slot k with
// segment k and an empty fill; s_axis_tready stays low until it ends
// the result sits in an output register, so the next word is taken while a
// result still waits; if the receiver stalls with a result waiting and a
// second one finished, the block holds that one and takes no more input
// at most one word is in work at a time
`timescale 1ns / 1ps
`default_nettype none

module segmented_arena_allocator
    import sas_pkg::*;
#(
    parameter int NUM_SEGMENTS  = NUM_SEGMENTS_DEF,
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // request_bytes[13:0], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // segment_id[7:0], byte_offset[21:8], zero pad
    output logic      [0:0]  m_axis_tuser   // status[0]
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic [SEG_ID_W-1:0] out_seg;
    logic [OFF_W-1:0]    out_off;
    logic                out_status;

    // sequencer: walks init, scan, swap and clear steps
    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_stat     (dp_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    // slot tables, search start, used top and the result register
    sas_dp #(
        .NUM_SEGMENTS  (NUM_SEGMENTS),
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_in_cmd     (s_axis_tuser),
        .i_in_req     (s_axis_tdata[REQ_W-1:0]),
        .i_out_ready  (m_axis_tready),
        .o_stat       (dp_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_seg    (out_seg),
        .o_out_off    (out_off),
        .o_out_status (out_status)
    );

    // output word packing, first field lowest
    assign m_axis_tdata = {2'b00, out_off, out_seg};
    assign m_axis_tuser = out_status;

    // at most one table write per cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.init_step, dp_cmd.wr_k, dp_cmd.wr_ss, dp_cmd.clr_step}))
        else $error("more than one table write in one cycle");

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");

    // no input taken while the tables are being written
    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(dp_cmd.init_step || dp_cmd.wr_k || dp_cmd.wr_ss
                            || dp_cmd.clr_step))
        else $error("input ready during table update");

    // one word in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while busy");

endmodule

`default_nettype wire

// ===== hw/rtl/sas_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/sas_ctrl.sv =====
// controller state machine of the segmented arena allocator
`timescale 1ns / 1ps
`default_nettype none

module sas_ctrl
    import sas_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_in_cmd,
    input  wire t_dp_stat         i_stat,
    output logic                  o_in_ready,
    output t_dp_cmd               o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_ALLOC) begin
                        n_state = S_A_LDS;
                    end else if (i_in_cmd == CMD_RESET) begin
                        n_state = S_CLR;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_A_LDS: n_state = S_A_RD;
            S_A_RD: begin
                n_state = i_stat.k_at_end ? S_DONE : S_A_CHK;
            end
            S_A_CHK: begin
                n_state = i_stat.fits ? S_A_WRK : S_A_RD;
            end
            S_A_WRK: n_state = S_A_WRS;
            S_A_WRS: n_state = S_DONE;
            S_CLR: begin
                if (i_stat.k_at_ut) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: o_cmd.init_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    o_cmd.rd_ss  = (i_in_cmd == CMD_ALLOC);
                    o_cmd.freeze = (i_in_cmd == CMD_FREEZE);
                end
            end
            S_A_LDS: o_cmd.ld_ss = 1'b1;
            S_A_RD: begin
                if (i_stat.k_at_end) begin
                    o_cmd.set_err = 1'b1;
                end else begin
                    o_cmd.rd_k = 1'b1;
                end
            end
            S_A_CHK: o_cmd.chk = 1'b1;
            S_A_WRK: o_cmd.wr_k = 1'b1;
            S_A_WRS: o_cmd.wr_ss = 1'b1;
            S_CLR: begin
                if (i_stat.k_at_ut) begin
                    o_cmd.clr_end = 1'b1;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_DONE: o_cmd.finish = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sas_dp.sv =====
// datapath of the segmented arena allocator: slot tables, pointers and result register
`timescale 1ns / 1ps
`default_nettype none

module sas_dp
    import sas_pkg::*;
#(
    parameter int NUM_SEGMENTS  = NUM_SEGMENTS_DEF,
    parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [CMD_W-1:0]      i_in_cmd,
    input  wire logic [REQ_W-1:0]      i_in_req,
    input  wire logic                  i_out_ready,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    output logic      [SEG_ID_W-1:0]   o_out_seg,
    output logic      [OFF_W-1:0]      o_out_off,
    output logic                       o_out_status
);

    localparam int IW    = $clog2(NUM_SEGMENTS);
    localparam int CW    = $clog2(NUM_SEGMENTS + 1);
    localparam int FW    = $clog2(SEGMENT_BYTES + 1);
    localparam int SUM_W = ((FW > REQ_W) ? FW : REQ_W) + 1;

    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_ss;
    logic [CW-1:0]    r_ut;
    logic [CMD_W-1:0] r_cmd;
    logic [REQ_W-1:0] r_req;
    logic             r_err;
    logic [IW-1:0]    r_seg_ss;
    logic [FW-1:0]    r_fill_ss;
    logic [IW-1:0]    r_seg_k;
    logic [FW-1:0]    r_off;
    logic             r_out_valid;
    logic [SEG_ID_W-1:0] r_out_seg;
    logic [OFF_W-1:0] r_out_off;
    logic             r_out_status;

    logic [IW-1:0]    seg_rdata;
    logic [FW-1:0]    fill_rdata;
    logic [IW-1:0]    raddr;
    logic             seg_we;
    logic             fill_we;
    logic [IW-1:0]    waddr;
    logic [IW-1:0]    seg_wdata;
    logic [FW-1:0]    fill_wdata;
    logic [SUM_W-1:0] fit_sum;
    logic [CW-1:0]    k_next;
    logic             out_free;
    logic             alloc_ok;

    assign k_next   = r_k + CW'(1);
    assign fit_sum  = SUM_W'(fill_rdata) + SUM_W'(r_req);
    assign out_free = !r_out_valid || i_out_ready;
    assign raddr    = i_cmd.rd_ss ? r_ss[IW-1:0] : r_k[IW-1:0];
    assign alloc_ok = (r_cmd == CMD_ALLOC) && !r_err;

    // write port selection
    always_comb begin
        seg_we     = 1'b0;
        fill_we    = 1'b0;
        waddr      = r_k[IW-1:0];
        seg_wdata  = r_k[IW-1:0];
        fill_wdata = '0;
        priority if (i_cmd.init_step) begin
            seg_we  = 1'b1;
            fill_we = 1'b1;
        end else if (i_cmd.wr_k) begin
            seg_we     = 1'b1;
            fill_we    = 1'b1;
            seg_wdata  = r_seg_ss;
            fill_wdata = r_fill_ss;
        end else if (i_cmd.wr_ss) begin
            seg_we     = 1'b1;
            fill_we    = 1'b1;
            waddr      = r_ss[IW-1:0];
            seg_wdata  = r_seg_k;
            fill_wdata = FW'(SUM_W'(r_off) + SUM_W'(r_req));
        end else if (i_cmd.clr_step) begin
            fill_we = 1'b1;
        end else begin
            seg_we = 1'b0;
        end
    end

    sas_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (seg_we),
        .i_waddr (waddr),
        .i_wdata (seg_wdata),
        .i_raddr (raddr),
        .o_rdata (seg_rdata)
    );

    sas_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_SEGMENTS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (waddr),
        .i_wdata (fill_wdata),
        .i_raddr (raddr),
        .o_rdata (fill_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_ss        <= '0;
            r_ut        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_step || i_cmd.clr_step) begin
                r_k <= k_next;
            end else if (i_cmd.accept) begin
                r_k <= r_ss;
            end else if (i_cmd.chk && !o_stat.fits) begin
                r_k <= k_next;
            end
            if (i_cmd.freeze) begin
                r_ss <= r_ut;
            end
            if (i_cmd.clr_end) begin
                r_ut <= r_ss;
            end else if (i_cmd.wr_ss && (k_next > r_ut)) begin
                r_ut <= k_next;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_in_cmd;
            r_req <= i_in_req;
        end
        if (i_cmd.accept) begin
            r_err <= 1'b0;
        end else if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.ld_ss) begin
            r_seg_ss  <= seg_rdata;
            r_fill_ss <= fill_rdata;
        end
        if (i_cmd.chk && o_stat.fits) begin
            r_seg_k <= seg_rdata;
            r_off   <= fill_rdata;
        end
        if (i_cmd.finish) begin
            r_out_seg    <= alloc_ok ? SEG_ID_W'(r_seg_k) : '0;
            r_out_off    <= alloc_ok ? OFF_W'(r_off) : '0;
            r_out_status <= (r_cmd == CMD_ALLOC) && r_err;
        end
    end

    always_comb begin
        o_stat.init_last = (r_k == CW'(NUM_SEGMENTS - 1));
        o_stat.k_at_end  = (r_k == CW'(NUM_SEGMENTS));
        o_stat.k_at_ut   = (r_k == r_ut);
        o_stat.fits      = (fit_sum <= SUM_W'(SEGMENT_BYTES));
        o_stat.out_free  = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_seg    = r_out_seg;
    assign o_out_off    = r_out_off;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire
